>>> rtl/u8bmp_pkg.sv
// shared constants and types of the utf-8 to bmp code point decoder
// no dependencies; imported by utf8_to_bmp_code_decoder_top
`default_nettype none

package u8bmp_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned CODE_W  = 16;
   localparam int unsigned CHUNK_W = 6;
   localparam int unsigned LEAD_W  = 5;
   localparam int unsigned SKIP_W  = 2;

   localparam logic [BYTE_W-1:0] LEAD_MIN  = 8'd192;
   localparam logic [BYTE_W-1:0] LEAD3_MIN = 8'd224;
   localparam logic [BYTE_W-1:0] LEAD4_MIN = 8'd240;
   localparam logic [CODE_W-1:0] BAD_CODE  = 16'd63;
   localparam logic [SKIP_W-1:0] SKIP_LEN  = 2'd3;

   typedef enum logic [2:0] {
      PH_IDLE     = 3'b001,
      PH_WAIT_END = 3'b010,
      PH_WAIT_MID = 3'b100
   } phase_type;

endpackage

`default_nettype wire

>>> rtl/utf8_to_bmp_code_decoder_top.sv
// utf-8 to 16-bit bmp code point decoder, one byte per transfer
// depends on u8bmp_pkg for constants and the phase type
//
// usage:
//   req_* : input stream, one raw utf-8 byte per transfer in req_tdata
//   rsp_* : result stream, one 16-bit code point per transfer in rsp_tdata
//   a byte may cause no result (lead bytes, middle bytes, skipped bytes);
//   every other byte causes exactly one result
// output: a result is registered and appears on rsp_* in the cycle after the byte's transfer
// throughput: one byte per cycle while rsp_* is not stalled; the decode of a byte and the state update
//   happen between the req transfer and the rsp output register
// stall: while rsp_tvalid is high and rsp_tready low, the output register
//   holds and req_tready drops; req_tready is high whenever the output
//   register is empty or being taken in the same cycle
// reset: synchronous, active high; clears the phase, stored lead and middle
//   bytes, the skip count and the output valid; no result is pending after
// a byte of 240 or more gives 63 and then drops the next three bytes below 192
//   that arrive while the decoder is idle
`default_nettype none

module utf8_to_bmp_code_decoder_top (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_tvalid,
   output logic                           req_tready,
   input  wire  [u8bmp_pkg::BYTE_W-1:0]   req_tdata,   // [7:0] in_byte
   output logic                           rsp_tvalid,
   input  wire                            rsp_tready,
   output logic [u8bmp_pkg::CODE_W-1:0]   rsp_tdata    // [15:0] code_point
);
   import u8bmp_pkg::*;

   phase_type           phase_ff, phase_in;
   logic [BYTE_W-1:0]   lead_ff, lead_in;
   logic [BYTE_W-1:0]   mid_ff, mid_in;
   logic [SKIP_W-1:0]   skip_ff, skip_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0]   rsp_data_ff, rsp_data_in;

   logic                req_xfer;
   logic                emit;
   logic [CODE_W-1:0]   code;
   logic [CODE_W-1:0]   seq_code;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // a nonzero middle byte, stale or real, gives a three-level assembly
   always_comb begin
      if (mid_ff != '0) begin
         seq_code = {lead_ff[CODE_W-2*CHUNK_W-1:0], mid_ff[CHUNK_W-1:0],
                     req_tdata[CHUNK_W-1:0]};
      end else begin
         seq_code = {{(CODE_W-LEAD_W-CHUNK_W){1'b0}}, lead_ff[LEAD_W-1:0],
                     req_tdata[CHUNK_W-1:0]};
      end
   end

   always_comb begin
      phase_in = phase_ff;
      lead_in  = lead_ff;
      mid_in   = mid_ff;
      skip_in  = skip_ff;
      emit     = 1'b0;
      code     = {{(CODE_W-BYTE_W){1'b0}}, req_tdata};
      if (req_tdata >= LEAD4_MIN) begin
         phase_in = PH_IDLE;
         lead_in  = '0;
         skip_in  = SKIP_LEN;
         emit     = 1'b1;
         code     = BAD_CODE;
      end else if (req_tdata >= LEAD3_MIN) begin
         lead_in  = req_tdata;
         phase_in = PH_WAIT_MID;
      end else if (req_tdata >= LEAD_MIN) begin
         lead_in  = req_tdata;
         phase_in = PH_WAIT_END;
      end else begin
         case (phase_ff)
            PH_WAIT_END: begin
               emit     = 1'b1;
               code     = seq_code;
               phase_in = PH_IDLE;
               lead_in  = '0;
               mid_in   = '0;
            end
            PH_WAIT_MID: begin
               mid_in   = req_tdata;
               phase_in = PH_WAIT_END;
            end
            default: begin
               phase_in = PH_IDLE;
               if (skip_ff != '0) begin
                  skip_in = skip_ff - SKIP_W'(1);
               end else begin
                  emit = 1'b1;
               end
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (req_xfer) begin
         rsp_valid_in = emit;
         rsp_data_in  = code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         lead_ff      <= '0;
         mid_ff       <= '0;
         skip_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_xfer) begin
            phase_ff <= phase_in;
            lead_ff  <= lead_in;
            mid_ff   <= mid_in;
            skip_ff  <= skip_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // four-byte lead always answers with the replacement code
   a_bad_lead: assert property (@(posedge clock) disable iff (reset)
      req_xfer && (req_tdata >= LEAD4_MIN) |=> rsp_valid_ff && rsp_data_ff == BAD_CODE)
      else $error("four-byte lead did not produce the replacement code");

   // plain byte while idle and not skipping passes through
   a_pass: assert property (@(posedge clock) disable iff (reset)
      req_xfer && (req_tdata < LEAD_MIN) && phase_ff == PH_IDLE && skip_ff == '0
      |=> rsp_valid_ff && rsp_data_ff == {{(CODE_W-BYTE_W){1'b0}}, $past(req_tdata)})
      else $error("idle byte did not pass through");

   // lead bytes of two- and three-byte sequences give no result
   a_lead_silent: assert property (@(posedge clock) disable iff (reset)
      req_xfer && (req_tdata >= LEAD_MIN) && (req_tdata < LEAD4_MIN) |=> !rsp_valid_ff)
      else $error("sequence lead byte produced a result");

   // skip count never exceeds its start value
   a_skip_range: assert property (@(posedge clock) disable iff (reset)
      skip_ff <= SKIP_LEN)
      else $error("skip count out of range");

endmodule

`default_nettype wire

>>> dv/utf8_to_bmp_code_decoder_top_tb.sv
// self-checking testbench of the utf-8 to bmp code point decoder: a scoreboard
// class predicts code points per accepted byte; needs u8bmp_pkg and the top rtl
`default_nettype none

module utf8_to_bmp_code_decoder_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import u8bmp_pkg::*;

   localparam logic [BYTE_W-1:0] LEAD_MASK   = 8'd31;
   localparam logic [BYTE_W-1:0] CHUNK_MASK  = 8'd63;
   localparam int unsigned       TARGET_BYTES = 1250;
   localparam int unsigned       QUIET_BYTES  = 1050;
   localparam int unsigned       CYCLE_LIMIT  = 400000;

   class code_point_scoreboard;
      logic [CODE_W-1:0] expected_codes[$];
      phase_type         phase;
      logic [BYTE_W-1:0] lead_byte;
      logic [BYTE_W-1:0] middle_byte;
      logic [2:0]        skip_count;
      int unsigned       mismatches;
      int unsigned       bytes_seen;
      int unsigned       codes_seen;
      int unsigned       bad_leads;

      function new();
         phase       = PH_IDLE;
         lead_byte   = '0;
         middle_byte = '0;
         skip_count  = '0;
         mismatches  = 0;
         bytes_seen  = 0;
         codes_seen  = 0;
         bad_leads   = 0;
      endfunction

      // returns 1 when the byte produces a code point
      function bit decode_byte(input logic [BYTE_W-1:0] b, output logic [CODE_W-1:0] code);
         logic [CODE_W-1:0] acc;
         code = '0;
         if (b >= LEAD4_MIN) begin
            phase      = PH_IDLE;
            lead_byte  = '0;
            skip_count = 3'(SKIP_LEN);
            bad_leads++;
            code = BAD_CODE;
            return 1'b1;
         end
         if (b >= LEAD3_MIN) begin
            lead_byte = b;
            phase     = PH_WAIT_MID;
            return 1'b0;
         end
         if (b >= LEAD_MIN) begin
            lead_byte = b;
            phase     = PH_WAIT_END;
            return 1'b0;
         end
         case (phase)
            PH_WAIT_END: begin
               acc = CODE_W'(lead_byte & LEAD_MASK) << CHUNK_W;
               // a stale or real nonzero middle byte adds one more chunk level
               if (middle_byte != '0) begin
                  acc = acc | CODE_W'(middle_byte & CHUNK_MASK);
                  acc = acc << CHUNK_W;
               end
               acc = acc | CODE_W'(b & CHUNK_MASK);
               phase       = PH_IDLE;
               lead_byte   = '0;
               middle_byte = '0;
               code = acc;
               return 1'b1;
            end
            PH_WAIT_MID: begin
               middle_byte = b;
               phase       = PH_WAIT_END;
               return 1'b0;
            end
            default: begin
               phase = PH_IDLE;
               if (skip_count != '0) begin
                  skip_count = skip_count - 3'd1;
                  return 1'b0;
               end
               code = CODE_W'(b);
               return 1'b1;
            end
         endcase
      endfunction

      function void note_byte(input logic [BYTE_W-1:0] b);
         logic [CODE_W-1:0] code;
         bytes_seen++;
         if (decode_byte(b, code))
            expected_codes = {expected_codes, code};
      endfunction

      function void check_code(input logic [CODE_W-1:0] actual);
         logic [CODE_W-1:0] want;
         codes_seen++;
         if (expected_codes.size() == 0) begin
            $error("code_point unexpected: expected none, actual %0d", actual);
            mismatches++;
         end else begin
            want = expected_codes.pop_front();
            if (actual !== want) begin
               $error("code_point mismatch: expected %0d, actual %0d", want, actual);
               mismatches++;
            end
         end
      endfunction
   endclass

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [BYTE_W-1:0] req_tdata  = '0;     // [7:0] in_byte
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [CODE_W-1:0] rsp_tdata;           // [15:0] code_point

   code_point_scoreboard sb = new();
   bit          idle_on     = 1'b1;
   int unsigned bytes_sent  = 0;
   int unsigned cycle_count = 0;

   utf8_to_bmp_code_decoder_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   // values at the falling edge are the ones the next rising edge sees
   always @(negedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_byte(req_tdata);
         if (rsp_tvalid && rsp_tready)
            sb.check_code(rsp_tdata);
      end
   end

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      bit taken;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
      bytes_sent++;
   endtask

   // continuation byte, now and then any byte below the lead range
   function automatic logic [BYTE_W-1:0] cont_byte();
      if ($urandom_range(0, 7) == 0)
         return BYTE_W'($urandom_range(0, 191));
      return BYTE_W'($urandom_range(128, 191));
   endfunction

   // receiver back-pressure
   initial begin
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (idle_on && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock) cycle_count++;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      logic [BYTE_W-1:0] directed[$];
      int unsigned       kind;
      int unsigned       n;
      // strays, two-byte and three-byte extremes, four-byte lead with a lead
      // inside its skip run, stale middle byte, zero middle byte
      directed = '{8'h00, 8'h80, 8'hBF, 8'h7F,
                   8'hC0, 8'h80, 8'hDF, 8'hBF,
                   8'hE0, 8'h80, 8'h80, 8'hEF, 8'hBF, 8'hBF,
                   8'hFF, 8'hC2, 8'hA9, 8'h81, 8'h82, 8'h83,
                   8'hE1, 8'h85, 8'hC3, 8'hA9,
                   8'hE2, 8'h00, 8'h41};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_byte(directed[i]);

      while (bytes_sent < TARGET_BYTES) begin
         if (bytes_sent >= QUIET_BYTES)
            idle_on = 1'b0;
         kind = $urandom_range(0, 99);
         if (kind < 20) begin
            send_byte(BYTE_W'($urandom_range(0, 127)));
         end else if (kind < 42) begin
            send_byte(BYTE_W'($urandom_range(192, 223)));
            send_byte(cont_byte());
         end else if (kind < 64) begin
            send_byte(BYTE_W'($urandom_range(224, 239)));
            send_byte(cont_byte());
            send_byte(cont_byte());
         end else if (kind < 76) begin
            send_byte(BYTE_W'($urandom_range(240, 255)));
            repeat (3) send_byte(cont_byte());
         end else if (kind < 88) begin
            // sequence cut short; the next lead restarts decoding
            send_byte(BYTE_W'($urandom_range(192, 239)));
            n = $urandom_range(0, 1);
            repeat (n) send_byte(cont_byte());
            send_byte(BYTE_W'($urandom_range(192, 255)));
         end else begin
            send_byte(BYTE_W'($urandom_range(0, 255)));
         end
      end
      req_tvalid <= 1'b0;

      while (sb.expected_codes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("sent %0d bytes, checked %0d code points, %0d of them four-byte leads",
               sb.bytes_seen, sb.codes_seen, sb.bad_leads);
      $display("stream mixed well-formed, truncated and noise sequences under back-pressure");
      if (sb.mismatches == 0 && sb.expected_codes.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

`default_nettype wire

>>> files.f
rtl/u8bmp_pkg.sv
rtl/utf8_to_bmp_code_decoder_top.sv
dv/utf8_to_bmp_code_decoder_top_tb.sv
